@@ src/dgs_pkg.sv @@
// Package for the discrete Gaussian sampler: widths, register indexes, exp ROM.
// No dependencies.
package dgs_pkg;
    localparam int TABLE_SIZE_DEF   = 64;
    localparam int UNIFORM_BITS_DEF = 16;
    localparam int CUM_W            = 22;
    localparam int ROM_DEPTH        = 256;

    localparam logic [1:0] REG_CENTER = 2'd0;
    localparam logic [1:0] REG_SPREAD = 2'd1;
    localparam logic [1:0] REG_LOW    = 2'd2;
    localparam logic [1:0] REG_HIGH   = 2'd3;

    // round(65536*exp(-i/16)), entry 0 saturated
    function automatic logic [15:0] exp_rom(input logic [7:0] i);
        real v;
        v = 65536.0 * $exp(-$itor(i) / 16.0) + 0.5;
        if (v > 65535.0) v = 65535.0;
        return 16'($rtoi(v));
    endfunction
endpackage

@@ src/dgs_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module dgs_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

@@ src/discrete_gaussian_sampler_top.sv @@
// Discrete Gaussian sampler, inverse CDF, top level.
// Uses dgs_pkg and dgs_ram.
//
// s_axis carries a uniform fraction (tdata[15:0]); m_axis returns one sample
// (tdata[5:0]) per accepted input. APB registers: 0 center_q8, 1 spread_q8,
// 2 range_low, 3 range_high; any write forces a table rebuild.
// After a register write the next input first rebuilds the cumulative table:
// per weight point, a serial divider forms the exp index; with n = min(range_high,
// TABLE_SIZE)-range_low bins a rebuild covers n+1 weight points.
// With a valid table a sample takes one RAM read of the total, a multiply
// to form the target, then a binary search of at most ceil(log2(n)) steps,
// each with a registered RAM read (S_READ, S_EVAL). A new input is taken only
// after the result has been accepted and the block is back in IDLE.
// An empty range goes from IDLE straight to DONE, a zero total from S_STEP.
// s_tready is high only when idle and no APB write is active.
// The result sits in an output register until m_tready takes it; the block
// accepts no input while a result waits. Reset restores register defaults
// and marks the table invalid; the RAM is not cleared.
module discrete_gaussian_sampler_top #(
    parameter int TABLE_SIZE   = dgs_pkg::TABLE_SIZE_DEF,
    parameter int UNIFORM_BITS = dgs_pkg::UNIFORM_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((UNIFORM_BITS+7)/8)*8-1:0] s_tdata, // uniform_fraction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // sample_value [5:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dgs_pkg::*;
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int IW = AW + 1;            // holds TABLE_SIZE itself

    typedef enum logic [3:0] {
        IDLE, B_INIT, B_DIV, B_ACC, MUL, S_STEP, S_READ, S_EVAL, DONE
    } state_t;
    state_t state_reg;

    logic [13:0] center_reg, spread_reg;
    logic [5:0]  low_reg;
    logic [6:0]  high_reg;
    logic        valid_reg;

    // effective range
    logic [IW-1:0] lo, hi;
    always_comb begin
        lo = IW'(low_reg);
        hi = (32'(high_reg) > TABLE_SIZE) ? IW'(TABLE_SIZE) : IW'(high_reg);
    end

    // APB
    assign pready = 1'b1;
    logic wr;
    assign wr = psel && penable && pwrite;
    always_comb begin
        case (paddr[3:2])
            REG_CENTER: prdata = 32'(center_reg);
            REG_SPREAD: prdata = 32'(spread_reg);
            REG_LOW:    prdata = 32'(low_reg);
            default:    prdata = 32'(high_reg);
        endcase
    end

    // datapath registers
    logic [UNIFORM_BITS-1:0] u_reg;
    logic [IW-1:0]    x_reg;         // weight point / bin index
    logic [15:0]      prev_reg;
    logic [CUM_W-1:0] run_reg, target_reg;
    logic [33:0]      num_reg;       // 8*mag^2, dividend/remainder shift
    logic [27:0]      den_reg;       // s^2
    logic [33:0]      rem_reg;
    logic [33:0]      quo_reg;
    logic [5:0]       cnt_reg;
    logic             first_reg;
    logic [IW-1:0]    blo_reg, bhi_reg; // search window [blo,bhi], bhi inclusive
    logic [IW-1:0]    mid_reg;
    logic [5:0]       res_reg;

    // RAM
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [CUM_W-1:0] wdata, rdata;
    dgs_ram #(.WIDTH(CUM_W), .DEPTH(TABLE_SIZE)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // distance mag of the current point from the center, and the effective spread
    logic [15:0] pos, mag;
    logic [13:0] s_eff;
    always_comb begin
        pos   = 16'(x_reg) << 8;
        mag   = (pos >= 16'(center_reg)) ? pos - 16'(center_reg)
                                         : 16'(center_reg) - pos;
        s_eff = (spread_reg == 14'd0) ? 14'd1 : spread_reg;
    end

    // restoring divider step
    logic [34:0] trial;
    assign trial = {rem_reg, num_reg[33]} - {7'd0, den_reg};

    logic [15:0] w_new;
    assign w_new = (quo_reg >= 34'(ROM_DEPTH)) ? 16'd0 : exp_rom(quo_reg[7:0]);
    logic [16:0] pair;
    assign pair = 17'(prev_reg) + 17'(w_new);

    always_comb begin
        we    = (state_reg == B_ACC) && !first_reg;
        waddr = AW'(x_reg - IW'(1));
        wdata = run_reg + CUM_W'(pair[16:1]);
        raddr = (state_reg == MUL) ? AW'(hi - IW'(1)) : AW'(mid_reg);
    end

    assign s_tready = (state_reg == IDLE) && !wr;
    assign m_tvalid = (state_reg == DONE);
    assign m_tdata  = {2'b00, res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= IDLE;
            center_reg <= 14'd8192;
            spread_reg <= 14'd1280;
            low_reg    <= 6'd0;
            high_reg   <= 7'd64;
            valid_reg  <= 1'b0;
        end else begin
            if (wr) begin
                valid_reg <= 1'b0;
                unique case (paddr[3:2])
                    REG_CENTER: center_reg <= pwdata[13:0];
                    REG_SPREAD: spread_reg <= pwdata[13:0];
                    REG_LOW:    low_reg    <= pwdata[5:0];
                    REG_HIGH:   high_reg   <= pwdata[6:0];
                endcase
            end
            unique case (state_reg)
                IDLE: if (s_tvalid && s_tready) begin
                    u_reg <= s_tdata[UNIFORM_BITS-1:0];
                    res_reg <= low_reg;
                    x_reg <= lo;
                    run_reg <= '0;
                    first_reg <= 1'b1;
                    if (lo >= hi) state_reg <= DONE;
                    else if (!valid_reg) state_reg <= B_INIT;
                    else state_reg <= MUL;
                end
                B_INIT: begin
                    num_reg <= {mag, 3'b000} * 34'(mag) >> 0;
                    den_reg <= 28'(s_eff) * 28'(s_eff);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= 6'd34;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    num_reg <= num_reg << 1;
                    if (!trial[34]) begin
                        rem_reg <= trial[33:0];
                        quo_reg <= {quo_reg[32:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[32:0], num_reg[33]};
                        quo_reg <= {quo_reg[32:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) state_reg <= B_ACC;
                end
                B_ACC: begin
                    prev_reg <= w_new;
                    first_reg <= 1'b0;
                    if (!first_reg) run_reg <= wdata;
                    if (!first_reg && x_reg == hi) begin
                        valid_reg <= 1'b1;
                        state_reg <= MUL;
                    end else begin
                        x_reg <= x_reg + IW'(1);
                        state_reg <= B_INIT;
                    end
                end
                MUL: begin
                    // raddr presents hi-1; data in S_STEP
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    target_reg <= CUM_W'((UNIFORM_BITS+CUM_W)'(u_reg)
                                  * (UNIFORM_BITS+CUM_W)'(rdata) >> UNIFORM_BITS);
                    blo_reg <= lo;
                    bhi_reg <= hi - IW'(1);  // fallback hi-1
                    if (rdata == '0) state_reg <= DONE;
                    else state_reg <= S_READ;
                end
                S_READ: begin
                    if (blo_reg >= bhi_reg) begin
                        res_reg <= 6'(bhi_reg);
                        state_reg <= DONE;
                    end else begin
                        mid_reg <= IW'((IW+1)'(blo_reg) + (IW+1)'(bhi_reg) >> 1);
                        state_reg <= S_EVAL;
                        cnt_reg <= 6'd0;
                    end
                end
                S_EVAL: begin
                    // first pass waits for the registered read
                    if (cnt_reg == 6'd0) cnt_reg <= 6'd1;
                    else begin
                        if (rdata > target_reg) bhi_reg <= mid_reg;
                        else blo_reg <= mid_reg + IW'(1);
                        state_reg <= S_READ;
                    end
                end
                DONE: if (m_tready) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> !s_tready)
        else $error("input taken while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == MUL) |-> valid_reg)
        else $error("search started on stale table");
endmodule

@@ tb/tb_discrete_gaussian_sampler_top.sv @@
// Self-checking bench for discrete_gaussian_sampler_top: stream stimulus,
// APB register phases, inline inverse-CDF predictor. Depends on dgs_pkg and the RTL.
module tb_discrete_gaussian_sampler_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dgs_pkg::*;

    localparam int NBINS = 64;
    localparam int WD_LIMIT = 20000;  // watchdog limit; a full 64-bin rebuild plus stalls fits within it

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [15:0] uniform_fraction
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [5:0] sample_value
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    discrete_gaussian_sampler_top uut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predictor state: shadow registers and the cumulative table.
    logic [13:0] cfg_center = 14'd8192, cfg_spread = 14'd1280;
    logic [5:0]  cfg_low = 6'd0;
    logic [6:0]  cfg_high = 7'd64;
    logic [21:0] cdf [NBINS];
    bit          cdf_fresh = 0;
    logic [15:0] exp_weights [ROM_DEPTH];

    logic [15:0] fraction_q [$];   // items waiting to be driven
    logic [5:0]  sample_q [$];     // predicted samples in order
    int          errors = 0;
    bit          hold_rx = 0;      // request for a long receiver hold-off

    // exp ROM computed in 60-bit fixed point, independent of the package's real path
    function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return 64'(p >> 60);
    endfunction

    initial begin : rom_init
        logic [63:0] step, term, p, v;
        step = 64'd1 << 60;
        term = step;
        p = step;
        for (int n = 1; n <= 24; n++) begin
            term = term / (16 * n);
            if (n % 2) step = step - term;
            else step = step + term;
        end
        for (int i = 0; i < ROM_DEPTH; i++) begin
            v = (p + (64'd1 << 43)) >> 44;
            exp_weights[i] = (v > 65535) ? 16'hFFFF : v[15:0];
            p = q60_mul(p, step);
        end
    end

    function automatic logic [16:0] bin_weight(int x);
        logic [63:0] pos, mag, s, idx;
        pos = x * 256;
        mag = (pos >= cfg_center) ? pos - cfg_center : cfg_center - pos;
        s = (cfg_spread == 0) ? 1 : cfg_spread;
        idx = (8 * mag * mag) / (s * s);
        return (idx >= ROM_DEPTH) ? 17'd0 : {1'b0, exp_weights[idx[7:0]]};
    endfunction

    function automatic int top_bin();
        return (cfg_high > NBINS) ? NBINS : int'(cfg_high);
    endfunction

    function automatic void rebuild_cdf();
        logic [21:0] run;
        logic [16:0] prev, nxt;
        run = 0;
        if (cfg_low < top_bin()) begin
            prev = bin_weight(cfg_low);
            for (int i = cfg_low; i < top_bin(); i++) begin
                nxt = bin_weight(i + 1);
                run = run + ((prev + nxt) >> 1);
                cdf[i] = run;
                prev = nxt;
            end
        end
        cdf_fresh = 1;
    endfunction

    function automatic logic [5:0] predict_sample(logic [15:0] u);
        int hi;
        logic [21:0] total;
        logic [37:0] target;
        logic [5:0] r;
        if (!cdf_fresh) rebuild_cdf();
        hi = top_bin();
        r = cfg_low;
        if (cfg_low < hi) begin
            total = cdf[hi - 1];
            if (total != 0) begin
                target = (38'(u) * total) >> 16;
                r = 6'(hi - 1);
                for (int i = cfg_low; i < hi; i++) begin
                    if (cdf[i] > target) begin
                        r = 6'(i);
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    // Sender: random idle gap between items (sometimes back to back), tvalid held until the transfer.
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sample_q.push_back(predict_sample(s_tdata));
                void'(fraction_q.pop_front());
                tx_gap <= $urandom_range(0, 3);
                if (fraction_q.size() > 0 && $urandom_range(0, 3) == 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= fraction_q[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid && fraction_q.size() > 0) begin
                if (tx_gap == 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= fraction_q[0];
                end else begin
                    tx_gap <= tx_gap - 1;
                end
            end
        end
    end

    // Receiver: random stall per result, plus a long hold-off on request.
    int rx_gap = 0;
    int hold_cnt = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_rx && hold_cnt < 400) begin
                hold_cnt <= hold_cnt + 1;
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                rx_gap <= $urandom_range(0, 3);
                m_tready <= ($urandom_range(0, 3) == 0);
            end else if (rx_gap == 0) begin
                m_tready <= 1'b1;
            end else begin
                rx_gap <= rx_gap - 1;
                m_tready <= 1'b0;
            end
        end
    end

    // Monitor: compare every sample transfer with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sample_q.size() == 0) begin
                $error("sample_value: unexpected transfer, actual %0d", m_tdata[5:0]);
                errors++;
            end else if (m_tdata[5:0] !== sample_q[0]) begin
                $error("sample_value: expected %0d actual %0d", sample_q[0], m_tdata[5:0]);
                errors++;
                void'(sample_q.pop_front());
            end else begin
                void'(sample_q.pop_front());
            end
        end
    end

    // Watchdog: cycles with no transfer on either stream.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("tb_discrete_gaussian_sampler_top: errors");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_CENTER: cfg_center = val[13:0];
            REG_SPREAD: cfg_spread = val[13:0];
            REG_LOW:    cfg_low    = val[5:0];
            default:    cfg_high   = val[6:0];
        endcase
        cdf_fresh = 0;
    endtask

    // Block is idle once every queued item went through and all samples came back.
    task automatic drain();
        while (fraction_q.size() > 0 || s_tvalid || sample_q.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_config(int c, int s, int lo, int hi);
        drain();
        apb_write(REG_CENTER, c);
        apb_write(REG_SPREAD, s);
        apb_write(REG_LOW, lo);
        apb_write(REG_HIGH, hi);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) fraction_q.push_back(16'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset config, fraction extremes and alternating bits.
        fraction_q.push_back(16'h0000);
        fraction_q.push_back(16'hFFFF);
        fraction_q.push_back(16'h8000);
        fraction_q.push_back(16'h5555);
        fraction_q.push_back(16'hAAAA);
        fraction_q.push_back(16'h0001);
        // Long hold-off with items still offered: fills the output stage.
        hold_rx = 1;
        queue_random(6);
        drain();
        hold_rx = 0;

        // Zero spread, treated as one: all weight on bins 19 and 20, the two bins next to the center point.
        set_config(20 * 256, 0, 0, 64);
        fraction_q.push_back(16'h0000);
        fraction_q.push_back(16'hFFFF);
        // Empty range: range_low at or above range_high.
        set_config(8192, 1280, 40, 40);
        fraction_q.push_back(16'h1234);
        set_config(8192, 1280, 63, 1);
        fraction_q.push_back(16'hFFFF);
        // Zero total: center far away from a narrow range.
        set_config(16383, 1, 0, 4);
        fraction_q.push_back(16'h7FFF);
        fraction_q.push_back(16'hFFFF);
        // range_high above the table saturates; extreme spread.
        set_config(0, 16383, 0, 127);
        fraction_q.push_back(16'h0000);
        fraction_q.push_back(16'hFFFF);
        fraction_q.push_back(16'hC000);
        // Single-bin range, with range_high at the table size.
        set_config(16383, 16383, 63, 64);
        fraction_q.push_back(16'hFFFF);
        fraction_q.push_back(16'h0000);

        // Random phases, mostly small ranges to keep rebuilds short.
        for (int ph = 0; ph < 12; ph++) begin
            int lo, hi;
            lo = $urandom_range(0, 63);
            hi = (ph % 4 == 0) ? $urandom_range(1, 127) : lo + $urandom_range(1, 12);
            if (hi > 127) hi = 127;
            set_config($urandom_range(0, 16383),
                       (ph % 3 == 0) ? $urandom_range(0, 16383) : $urandom_range(64, 2048),
                       lo, hi);
            queue_random(40);
        end
        drain();

        if (errors == 0)
            $display("tb_discrete_gaussian_sampler_top: clean");
        else
            $display("tb_discrete_gaussian_sampler_top: errors");
        $finish;
    end
endmodule
